// ===== rtl/mpf_pkg.sv =====
// Package: shared constants and types of the MQTT publish framer.
`default_nettype none
package mpf_pkg;

  // Lengths are taken in their low LEN_W bits (range 8..16).
  localparam int LEN_W = 16;
  // Input field widths.
  localparam int FLD_LEN_W = 16;
  localparam int QOS_W     = 2;
  localparam int OCT_W     = 8;
  // Remaining length, padded to three 7-bit varint groups.
  localparam int VAR_W     = 21;
  localparam int VAR_GRP   = 7;
  // Most result bytes one transaction can cause, and widths to count/index them.
  localparam int MAX_RES   = 8;
  localparam int IDX_W     = $clog2(MAX_RES);
  localparam int CNT_W     = $clog2(MAX_RES + 1);
  localparam int ID_W      = 16;

  localparam logic [OCT_W-1:0] PUBLISH_HDR = 8'h30;
  localparam logic [OCT_W-1:0] VAR_CONT    = 8'h80;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  // One transaction's worth of result bytes, first byte in slot 0.
  typedef struct packed {
    logic [MAX_RES-1:0][OCT_W-1:0] data;
    logic [MAX_RES-1:0]            last;
    logic [CNT_W-1:0]              count;
  } burst_t;

endpackage
`default_nettype wire

// ===== rtl/mpf_if.sv =====
// Interfaces: input item channel and output byte channel.
`default_nettype none
interface mpf_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] topic_length;
  logic [15:0] message_length;
  logic [1:0]  qos_level;
  logic [7:0]  data_byte;

  modport source (output valid, op, topic_length, message_length, qos_level, data_byte,
                  input ready);
  modport sink   (input valid, op, topic_length, message_length, qos_level, data_byte,
                  output ready);
endinterface

interface mpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_packet;

  modport source (output valid, out_byte, last_of_packet, input ready);
  modport sink   (input valid, out_byte, last_of_packet, output ready);
endinterface
`default_nettype wire

// ===== rtl/mpf_encoder.sv =====
// Encoder: input register, packet state and result byte burst builder.
`default_nettype none
module mpf_encoder (
  input  wire logic           clk,
  input  wire logic           rst_n,
  mpf_in_if.sink              in_ch,
  input  wire logic           ser_ready,
  output logic                burst_v,
  output mpf_pkg::burst_t     burst
);
  import mpf_pkg::*;

  // input register
  logic                 item_v_r;
  logic                 op_r;
  logic [FLD_LEN_W-1:0] tlen_r;
  logic [FLD_LEN_W-1:0] mlen_r;
  logic [QOS_W-1:0]     qos_r;
  logic [OCT_W-1:0]     dbyte_r;

  // packet state
  logic [ID_W-1:0]  ident_r,      ident_nxt;
  logic [LEN_W-1:0] topic_left_r, topic_left_nxt;
  logic [LEN_W-1:0] msg_left_r,   msg_left_nxt;
  logic [QOS_W-1:0] pend_qos_r,   pend_qos_nxt;
  logic             in_pkt_r,     in_pkt_nxt;

  logic             in_fire;
  logic             load;
  logic [LEN_W-1:0] tl;
  logic [LEN_W-1:0] ml;
  logic [VAR_W-1:0] rem;
  logic [CNT_W-1:0] k;
  logic             do_after;

  assign load         = item_v_r && ser_ready;
  assign in_ch.ready  = !item_v_r || ser_ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign burst_v      = item_v_r;
  assign tl           = tlen_r[LEN_W-1:0];
  assign ml           = mlen_r[LEN_W-1:0];
  assign rem          = VAR_W'(2) + VAR_W'(tl) + VAR_W'(ml)
                      + ((qos_r != '0) ? VAR_W'(2) : VAR_W'(0));

  always_comb begin
    burst          = '0;
    k              = '0;
    do_after       = 1'b0;
    ident_nxt      = ident_r;
    topic_left_nxt = topic_left_r;
    msg_left_nxt   = msg_left_r;
    pend_qos_nxt   = pend_qos_r;
    in_pkt_nxt     = in_pkt_r;

    if (op_t'(op_r) == OP_START) begin
      burst.data[k[IDX_W-1:0]] = PUBLISH_HDR | OCT_W'({qos_r, 1'b0});
      k = k + 1'b1;
      // remaining length, base-128, low group first
      burst.data[k[IDX_W-1:0]] = {1'b0, rem[VAR_GRP-1:0]}
                               | ((rem[VAR_W-1:VAR_GRP] != '0) ? VAR_CONT : '0);
      k = k + 1'b1;
      if (rem[VAR_W-1:VAR_GRP] != '0) begin
        burst.data[k[IDX_W-1:0]] = {1'b0, rem[2*VAR_GRP-1:VAR_GRP]}
                                 | ((rem[VAR_W-1:2*VAR_GRP] != '0) ? VAR_CONT : '0);
        k = k + 1'b1;
      end
      if (rem[VAR_W-1:2*VAR_GRP] != '0) begin
        burst.data[k[IDX_W-1:0]] = {1'b0, rem[VAR_W-1:2*VAR_GRP]};
        k = k + 1'b1;
      end
      burst.data[k[IDX_W-1:0]] = tlen_r[FLD_LEN_W-1:OCT_W] & OCT_W'(tl >> OCT_W);
      k = k + 1'b1;
      burst.data[k[IDX_W-1:0]] = tl[OCT_W-1:0];
      burst.last[k[IDX_W-1:0]] = (tl == '0) && (qos_r == '0) && (ml == '0);
      k = k + 1'b1;
      topic_left_nxt = tl;
      msg_left_nxt   = ml;
      pend_qos_nxt   = qos_r;
      in_pkt_nxt     = 1'b1;
      do_after       = (tl == '0);
    end else if (in_pkt_r) begin
      if (topic_left_r != '0) begin
        topic_left_nxt = topic_left_r - 1'b1;
        burst.data[k[IDX_W-1:0]] = dbyte_r;
        burst.last[k[IDX_W-1:0]] = (topic_left_nxt == '0) && (pend_qos_r == '0)
                                 && (msg_left_r == '0);
        k = k + 1'b1;
        do_after = (topic_left_nxt == '0);
      end else if (msg_left_r != '0) begin
        msg_left_nxt = msg_left_r - 1'b1;
        burst.data[k[IDX_W-1:0]] = dbyte_r;
        burst.last[k[IDX_W-1:0]] = (msg_left_nxt == '0);
        k = k + 1'b1;
        if (msg_left_nxt == '0) begin
          in_pkt_nxt = 1'b0;
        end
      end else begin
        in_pkt_nxt = 1'b0;
      end
    end

    // topic done: owed packet identifier, then message phase
    if (do_after) begin
      if (pend_qos_nxt != '0) begin
        burst.data[k[IDX_W-1:0]] = ident_r[ID_W-1:OCT_W];
        k = k + 1'b1;
        burst.data[k[IDX_W-1:0]] = ident_r[OCT_W-1:0];
        burst.last[k[IDX_W-1:0]] = (msg_left_nxt == '0);
        k = k + 1'b1;
        ident_nxt    = ident_r + 1'b1;
        pend_qos_nxt = '0;
      end
      in_pkt_nxt = (msg_left_nxt != '0);
    end
    burst.count = k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r     <= 1'b0;
      ident_r      <= '0;
      topic_left_r <= '0;
      msg_left_r   <= '0;
      pend_qos_r   <= '0;
      in_pkt_r     <= 1'b0;
    end else begin
      if (in_fire) begin
        item_v_r <= 1'b1;
      end else if (load) begin
        item_v_r <= 1'b0;
      end
      if (load) begin
        ident_r      <= ident_nxt;
        topic_left_r <= topic_left_nxt;
        msg_left_r   <= msg_left_nxt;
        pend_qos_r   <= pend_qos_nxt;
        in_pkt_r     <= in_pkt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_ch.op;
      tlen_r  <= in_ch.topic_length;
      mlen_r  <= in_ch.message_length;
      qos_r   <= in_ch.qos_level;
      dbyte_r <= in_ch.data_byte;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mpf_serializer.sv =====
// Serializer: result register; drains a burst one byte per cycle while ready.
`default_nettype none
module mpf_serializer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           burst_v,
  input  mpf_pkg::burst_t     burst,
  output logic                ser_ready,
  mpf_out_if.source           out_ch
);
  import mpf_pkg::*;

  logic [MAX_RES-1:0][OCT_W-1:0] data_r;
  logic [MAX_RES-1:0]            last_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          out_fire;
  logic                          load;

  assign out_fire  = out_ch.valid && out_ch.ready;
  // empty, or the only byte left leaves this cycle
  assign ser_ready = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ch.ready);
  assign load      = burst_v && ser_ready;

  assign out_ch.valid          = (cnt_r != '0);
  assign out_ch.out_byte       = data_r[0];
  assign out_ch.last_of_packet = last_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= burst.count;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= burst.data;
      last_r <= burst.last;
    end else if (out_fire) begin
      data_r <= {OCT_W'(0), data_r[MAX_RES-1:1]};
      last_r <= {1'b0, last_r[MAX_RES-1:1]};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mqtt_publish_framer_unit.sv =====
// Top level: MQTT 3.1.1 PUBLISH packet framer.
// Latency: the first result byte of a transaction is registered in the encoder's input
//   register, then in the serializer's result register, before it is valid.
// Throughput: one data transaction per cycle while the output is ready; a start
//   transaction yields 4 to 8 bytes and the last topic byte with an owed identifier
//   yields 3; input stalls while the byte-wide output serializer sends them.
// Reset: synchronous, active low; clears the packet identifier, packet state
//   and both stage valids. Payload registers are not reset.
`default_nettype none
module mqtt_publish_framer_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  mpf_in_if.sink    in_ch,
  mpf_out_if.source out_ch
);
  import mpf_pkg::*;

  // Stage 1 (encoder): input register plus the packet state machine. When the
  // serializer can take a burst, the registered transaction is turned into up
  // to eight bytes: header, varint remaining length, topic length, topic or
  // message byte, and the packet identifier when QoS is owed.
  // Stage 2 (serializer): holds the burst and drains it one byte per cycle while
  // the output is ready. It takes the next burst in the same cycle its last byte
  // is taken, so a stream of data transactions runs at one per cycle when not stalled.
  logic   burst_v;
  burst_t burst;
  logic   ser_ready;

  mpf_encoder u_enc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .ser_ready (ser_ready),
    .burst_v   (burst_v),
    .burst     (burst)
  );

  // Data transactions outside a packet yield an empty burst and simply vanish.
  mpf_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .burst_v   (burst_v),
    .burst     (burst),
    .ser_ready (ser_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// ===== sim/mpf_checker.sv =====
// Checker: watches both channels, predicts the publish byte stream and compares it.
`timescale 1ns / 1ps
module mpf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_topic_length,
  input  logic [15:0] in_message_length,
  input  logic [1:0]  in_qos_level,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  input  logic        end_check,
  output int          fail_count,
  output int          pending,
  output int          bytes_seen
);
  import mpf_pkg::*;

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [OCT_W-1:0] data;
    logic             last;
  } frame_byte_t;

  frame_byte_t       frame_bytes[$];

  // predictor state
  logic [ID_W-1:0]   ident_ctr;
  logic [15:0]       topic_rem;
  logic [15:0]       msg_rem;
  logic [QOS_W-1:0]  ident_owed;
  logic              framing;
  logic              end_done;

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic push_byte(input logic [OCT_W-1:0] b, input logic last);
    frame_bytes.push_back('{data: b, last: last});
  endtask

  // topic done: owed identifier goes out, then message phase (if any)
  task automatic close_topic();
    if (ident_owed != '0) begin
      push_byte(ident_ctr[15:8], 1'b0);
      push_byte(ident_ctr[7:0], msg_rem == '0);
      ident_ctr  = ident_ctr + 1'b1;
      ident_owed = '0;
    end
    framing = (msg_rem != '0);
  endtask

  task automatic frame_transaction(input op_t op, input logic [15:0] tl_in,
                                   input logic [15:0] ml_in, input logic [1:0] q,
                                   input logic [7:0] d);
    logic [15:0]      tl;
    logic [15:0]      ml;
    logic [VAR_W-1:0] remaining;
    logic [OCT_W-1:0] grp;
    tl = '0;
    ml = '0;
    tl[LEN_W-1:0] = tl_in[LEN_W-1:0];
    ml[LEN_W-1:0] = ml_in[LEN_W-1:0];
    if (op == OP_START) begin
      remaining = VAR_W'(2) + VAR_W'(tl) + VAR_W'(ml) + ((q != '0) ? VAR_W'(2) : VAR_W'(0));
      push_byte(PUBLISH_HDR | {5'b0, q, 1'b0}, 1'b0);
      do begin
        grp       = {1'b0, remaining[VAR_GRP-1:0]};
        remaining = remaining >> VAR_GRP;
        if (remaining != '0) grp = grp | VAR_CONT;
        push_byte(grp, 1'b0);
      end while (remaining != '0);
      push_byte(tl[15:8], 1'b0);
      push_byte(tl[7:0], tl == '0 && q == '0 && ml == '0);
      topic_rem  = tl;
      msg_rem    = ml;
      ident_owed = q;
      framing    = 1'b1;
      if (tl == '0) close_topic();
    end else if (framing) begin
      if (topic_rem != '0) begin
        topic_rem = topic_rem - 1'b1;
        push_byte(d, topic_rem == '0 && ident_owed == '0 && msg_rem == '0);
        if (topic_rem == '0) close_topic();
      end else if (msg_rem != '0) begin
        msg_rem = msg_rem - 1'b1;
        push_byte(d, msg_rem == '0);
        if (msg_rem == '0) framing = 1'b0;
      end else begin
        framing = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst_n) begin
      ident_ctr  = '0;
      topic_rem  = '0;
      msg_rem    = '0;
      ident_owed = '0;
      framing    = 1'b0;
      end_done   = 1'b0;
      fail_count = 0;
      bytes_seen = 0;
      frame_bytes.delete();
    end else begin
      if (in_valid && in_ready) begin
        frame_transaction(op_t'(in_op), in_topic_length, in_message_length,
                          in_qos_level, in_data_byte);
      end
      if (out_valid && out_ready) begin
        bytes_seen++;
        if (frame_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last=%0b", out_byte, out_last));
        end else begin
          want = frame_bytes.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("byte %0d: got %02h want %02h",
                                      bytes_seen, out_byte, want.data));
          if (out_last !== want.last)
            report_mismatch($sformatf("byte %0d: last got %0b want %0b",
                                      bytes_seen, out_last, want.last));
        end
      end
      if (end_check && !end_done) begin
        end_done = 1'b1;
        if (frame_bytes.size() != 0)
          report_mismatch($sformatf("%0d expected bytes never came", frame_bytes.size()));
      end
    end
    pending <= frame_bytes.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top: drives publish items into the framer, paces the output and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import mpf_pkg::*;

  // Run length guard, generous against the slowest legal run.
  localparam int LIMIT_CYCLES = 300000;
  // Output hold-off long enough to back the block up into its input.
  localparam int HOLD_CYCLES  = 400;
  // Cycles to let pass after the last expected byte.
  localparam int TAIL_CYCLES  = 16;
  // Counted random items per idling phase; with the directed part, the
  // hold-off packet and the overshoot of the last packet of each phase,
  // the run sends about 270 items.
  localparam int PHASE_ITEMS  = 24;

  logic clk;
  logic rst_n;

  mpf_in_if  in_ch ();
  mpf_out_if out_ch ();

  mqtt_publish_framer_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int   chk_fails;
  int   chk_pending;
  int   chk_bytes;
  logic end_check;

  mpf_checker u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_op             (in_ch.op),
    .in_topic_length   (in_ch.topic_length),
    .in_message_length (in_ch.message_length),
    .in_qos_level      (in_ch.qos_level),
    .in_data_byte      (in_ch.data_byte),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_byte          (out_ch.out_byte),
    .out_last          (out_ch.last_of_packet),
    .end_check         (end_check),
    .fail_count        (chk_fails),
    .pending           (chk_pending),
    .bytes_seen        (chk_bytes)
  );

  // Pacing knobs. idle_pct is only touched by the stimulus process;
  // stall_pct and hold_requests cross into the receiver, so they are
  // written with nonblocking assignments at the clock edge.
  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int items_sent    = 0;   // every accepted input transaction
  int counted_items = 0;   // packet items that count toward the phase goals
  int cycles        = 0;

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d bytes still expected", cycles, chk_pending);
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stall per cycle, or a long hold-off when the
  // stimulus asks for one. The hold-off is counted here, not by the sender.
  initial begin : receiver
    int hold_left;
    int served;
    hold_left = 0;
    served    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != served) begin
        served    = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // One input transaction. Called at a rising-edge step; returns at the
  // rising-edge step where the item was taken, so the next call may keep
  // valid high without a dip. Ready is looked at on the falling edge,
  // where it is settled, to stay clear of same-step ordering.
  task automatic send_item(input op_t op, input logic [15:0] tl, input logic [15:0] ml,
                           input logic [1:0] q, input logic [7:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= op;
    in_ch.topic_length   <= tl;
    in_ch.message_length <= ml;
    in_ch.qos_level      <= q;
    in_ch.data_byte      <= d;
    do begin
      @(negedge clk);
    end while (!in_ch.ready);
    @(posedge clk);
    items_sent++;
  endtask

  // Start item: the data byte field is unused, so it gets noise.
  task automatic send_start(input logic [15:0] tl, input logic [15:0] ml, input logic [1:0] q);
    send_item(OP_START, tl, ml, q, 8'($urandom));
  endtask

  // Data item: the length and QoS fields are unused, so they get noise.
  task automatic send_data(input logic [7:0] d);
    send_item(OP_DATA, 16'($urandom), 16'($urandom), 2'($urandom), d);
  endtask

  task automatic send_data_run(input int n);
    for (int i = 0; i < n; i++) send_data(8'($urandom));
  endtask

  // Drop valid and hold the sender until every expected byte is out.
  // Ends on a rising-edge step so driving can resume right away.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (chk_pending == 0) break;
    end
    @(posedge clk);
  endtask

  // Mostly well-formed packets with random content, plus some stray data
  // and packets cut short by the next start.
  task automatic random_packet();
    int         kind;
    int         tl;
    int         ml;
    logic [1:0] q;
    kind = $urandom_range(99);
    q    = 2'($urandom_range(3));
    if (kind < 10) begin
      // stray byte: dropped if idle, else eaten by an open packet
      send_data(8'($urandom));
    end else if (kind < 20) begin
      // broken packet: any lengths, at most three bytes before the next start
      tl = $urandom_range(65535);
      ml = $urandom_range(65535);
      if ($urandom_range(1) == 1) tl = $urandom_range(8);
      send_start(16'(tl), 16'(ml), q);
      send_data_run($urandom_range(3));
      counted_items++;
    end else begin
      tl = $urandom_range(6);
      ml = $urandom_range(10);
      if (kind >= 95) begin
        // longer packet, one- or two-byte remaining length
        tl = $urandom_range(40, 90);
        ml = $urandom_range(20, 60);
      end
      send_start(16'(tl), 16'(ml), q);
      send_data_run(tl + ml);
      counted_items += 1 + tl + ml;
    end
  endtask

  initial begin : stimulus
    int phase_goal;
    rst_n                <= 1'b0;
    end_check            <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.op             <= OP_DATA;
    in_ch.topic_length   <= '0;
    in_ch.message_length <= '0;
    in_ch.qos_level      <= '0;
    in_ch.data_byte      <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed corners ----
    send_data(8'hA5);                  // data while idle: dropped
    send_start(16'd0, 16'd0, 2'd0);    // empty packet, last on topic length LSB
    send_start(16'd0, 16'd0, 2'd1);    // empty topic with QoS: id right after length
    send_start(16'd0, 16'd2, 2'd2);    // empty topic, id then message
    send_data(8'h00);
    send_data(8'hFF);
    send_start(16'd2, 16'd1, 2'd3);    // QoS three: header 0x36, id after topic
    send_data_run(3);
    send_start(16'd1, 16'd0, 2'd0);    // single topic byte carries the last flag
    send_data(8'h81);
    send_start(16'hFFFF, 16'hFFFF, 2'd3);  // three-byte remaining length, abandoned
    send_data_run(2);
    send_start(16'd100, 16'd30, 2'd0);     // two-byte remaining length, abandoned
    send_data_run(2);
    send_start(16'd0, 16'd0, 2'd0);    // start during a packet
    send_data(8'h5A);                  // idle again: dropped
    wait_drained();

    // ---- random phases: none / sender idle / receiver stall / both ----
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 86; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 86; end
        default: begin idle_pct = 31; stall_pct <= 31; end
      endcase
      if (phase == 0) begin
        // long output hold-off while the sender keeps pushing one packet,
        // so the block backs up and stalls its input
        hold_requests <= hold_requests + 1;
        send_start(16'd24, 16'd40, 2'd1);
        send_data_run(64);
        counted_items += 65;
        wait_drained();      // sender waits for every expected byte
      end
      phase_goal = counted_items + PHASE_ITEMS;
      while (counted_items < phase_goal) random_packet();
      wait_drained();
    end

    // ---- wrap-up ----
    idle_pct = 0;
    stall_pct <= 0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Run covered %0d input transactions and %0d checked output bytes in %0d cycles.",
             items_sent, chk_bytes, cycles);
    $display("Directed corners, four pacing phases and a long output hold-off; %0d mismatches.",
             chk_fails);
    if (chk_fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== mqtt_publish_framer_unit.f =====
rtl/mpf_pkg.sv
rtl/mpf_if.sv
rtl/mpf_encoder.sv
rtl/mpf_serializer.sv
rtl/mqtt_publish_framer_unit.sv
sim/mpf_checker.sv
sim/tb.sv
